[hdl/cpfm_pkg.sv]
// ----------------------------------------------------------------------------
// cpfm_pkg
// shared types and constants for the capture period and frequency meter
// ----------------------------------------------------------------------------
`default_nettype none

package cpfm_pkg;

  localparam int unsigned TPO_W      = 17;
  localparam int unsigned RATE_W     = 24;
  localparam int unsigned CAP_W      = 16;
  localparam int unsigned CNT32_W    = 32;
  localparam int unsigned FREQ_W     = 30;
  localparam int unsigned MILLI_W    = 10;
  localparam int unsigned NUM_W      = RATE_W + MILLI_W;
  localparam int unsigned DIV_STEPS  = NUM_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS + 1);
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = RATE_W;
  localparam int unsigned Q_DEPTH    = 4;
  localparam int unsigned Q_AW       = $clog2(Q_DEPTH);

  localparam logic [TPO_W-1:0]   TPO_RESET  = TPO_W'(50000);
  localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(1000000);
  localparam logic [MILLI_W-1:0] MILLI      = MILLI_W'(1000);
  localparam logic [FREQ_W-1:0]  FREQ_MAX   = FREQ_W'(999999999);

  localparam logic [CFG_IDX_W-1:0] CFG_TPO  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = CFG_IDX_W'(1);

  localparam logic OP_OVERFLOW = 1'b0;
  localparam logic OP_CAPTURE  = 1'b1;

  typedef struct packed {
    logic             operation;
    logic [CAP_W-1:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [CNT32_W-1:0] period_ticks;
    logic [FREQ_W-1:0]  freq_millihertz;
    logic               zero_period;
  } out_item_t;

  typedef struct packed {
    logic [CNT32_W-1:0] ovf_diff;
    logic [CNT32_W-1:0] cap_delta;
  } meas_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

[hdl/cpfm_front.sv]
// ----------------------------------------------------------------------------
// cpfm_front
// accepts overflow ticks and captures, pairs captures into measurements
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_front
  import cpfm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire q_stat_t  q_stat,
  output logic          push,
  output meas_t         push_data
);

  logic [CNT32_W-1:0] overflow_count;
  logic [CAP_W-1:0]   first_capture;
  logic [CNT32_W-1:0] first_overflow_stamp;
  logic               second_pending;
  logic               accept;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (in_data.operation == OP_CAPTURE) && second_pending;

  assign push_data.ovf_diff  = overflow_count - first_overflow_stamp;
  assign push_data.cap_delta = {{(CNT32_W-CAP_W){1'b0}}, in_data.capture_value}
                             - {{(CNT32_W-CAP_W){1'b0}}, first_capture};

  always_ff @(posedge clk) begin
    if (rst) begin
      overflow_count       <= '0;
      first_capture        <= '0;
      first_overflow_stamp <= '0;
      second_pending       <= 1'b0;
    end else if (accept) begin
      if (in_data.operation == OP_OVERFLOW) begin
        overflow_count <= overflow_count + CNT32_W'(1);
      end else if (!second_pending) begin
        first_capture        <= in_data.capture_value;
        first_overflow_stamp <= overflow_count;
        second_pending       <= 1'b1;
      end else begin
        second_pending <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/cpfm_queue.sv]
// ----------------------------------------------------------------------------
// cpfm_queue
// short fifo of pending measurements between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_queue
  import cpfm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire meas_t push_data,
  input  wire logic  pop,
  output meas_t      pop_data,
  output q_stat_t    q_stat
);

  meas_t           slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + Q_AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (Q_AW+1)'(1);
        2'b01:   count <= count - (Q_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/cpfm_back.sv]
// ----------------------------------------------------------------------------
// cpfm_back
// period assembly, bit-serial frequency division and output register
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_back
  import cpfm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire q_stat_t           q_stat,
  input  wire meas_t             pop_data,
  output logic                   pop,
  input  wire logic [TPO_W-1:0]  ticks_per_overflow,
  input  wire logic [RATE_W-1:0] reference_rate,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ADD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t               state;
  state_t               state_next;
  meas_t                meas;
  logic [CNT32_W-1:0]   product;
  logic [NUM_W-1:0]     num;
  logic [CNT32_W-1:0]   period;
  logic [CNT32_W-1:0]   rem;
  logic [STEP_W-1:0]    steps;
  logic                 zero;
  logic [CNT32_W:0]     shifted;
  logic [CNT32_W:0]     trial;
  logic                 ge;
  logic [CNT32_W-1:0]   period_sum;
  logic                 out_free;
  logic [TPO_W+CNT32_W-1:0]  mul_wide;
  logic [RATE_W+MILLI_W-1:0] num_wide;

  assign out_free   = !out_valid || !out_stall;
  assign pop        = (state == ST_IDLE) && !q_stat.empty;
  assign shifted    = {rem, num[NUM_W-1]};
  assign trial      = shifted - {1'b0, period};
  assign ge         = !trial[CNT32_W];
  assign period_sum = product + meas.cap_delta;
  assign mul_wide   = meas.ovf_diff * ticks_per_overflow;
  assign num_wide   = reference_rate * MILLI;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (!q_stat.empty) state_next = ST_MUL;
      ST_MUL:  state_next = ST_ADD;
      ST_ADD:  state_next = (period_sum == '0) ? ST_DONE : ST_DIV;
      ST_DIV:  if (steps == STEP_W'(1)) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        meas <= pop_data;
      end
      ST_MUL: begin
        product <= mul_wide[CNT32_W-1:0];
        num     <= NUM_W'(num_wide);
      end
      ST_ADD: begin
        period <= period_sum;
        zero   <= (period_sum == '0);
        rem    <= '0;
        steps  <= STEP_W'(DIV_STEPS);
      end
      ST_DIV: begin
        rem   <= ge ? trial[CNT32_W-1:0] : shifted[CNT32_W-1:0];
        num   <= {num[NUM_W-2:0], ge};
        steps <= steps - STEP_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_data.period_ticks <= period;
          out_data.zero_period  <= zero;
          if (zero) begin
            out_data.freq_millihertz <= '0;
          end else if (num > NUM_W'(FREQ_MAX)) begin
            out_data.freq_millihertz <= FREQ_MAX;
          end else begin
            out_data.freq_millihertz <= num[FREQ_W-1:0];
          end
        end
      end
      default: begin
        meas <= meas;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/capture_period_frequency_meter_top.sv]
// ----------------------------------------------------------------------------
// capture_period_frequency_meter_top
// input capture period and frequency meter
// ----------------------------------------------------------------------------
// input channel (in_valid/in_stall/in_data): one item per cycle at most, an
//   overflow tick or a capture edge with the 16-bit timer value. second
//   captures push a measurement into a four-entry queue, and in_stall rises
//   only while that queue is full, holding off every item, ticks included.
// output channel (out_valid/out_stall/out_data): one item per second
//   capture with the period in timer ticks and the frequency in mHz.
// a second capture's measurement passes through the queue, a multiply state,
//   an add state, 34 steps of a one bit per cycle restoring divider and the
//   output register; a zero period skips the divider. the back end takes
//   the next measurement from the queue only after the last result has
//   gone into the output register.
// a stalled result holds in the output register; the divider then waits
//   and the queue fills before the input side stalls.
// the user writes ticks_per_overflow (index 0) and reference_rate (index 1)
//   on cfg_write/cfg_index/cfg_data only while the block is idle; unenforced.
// synchronous reset clears the counters, the queue and out_valid, and
//   restores the register defaults of 50000 and 1000000.
// ----------------------------------------------------------------------------
`default_nettype none

module capture_period_frequency_meter_top
  import cpfm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TPO_W-1:0]  ticks_per_overflow;
  logic [RATE_W-1:0] reference_rate;
  q_stat_t           q_stat;
  logic              push;
  meas_t             push_data;
  logic              pop;
  meas_t             pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_overflow <= TPO_RESET;
      reference_rate     <= RATE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_TPO:  ticks_per_overflow <= cfg_data[TPO_W-1:0];
        CFG_RATE: reference_rate     <= cfg_data[RATE_W-1:0];
        default:  reference_rate     <= reference_rate;
      endcase
    end
  end

  cpfm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  cpfm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  cpfm_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_stat             (q_stat),
    .pop_data           (pop_data),
    .pop                (pop),
    .ticks_per_overflow (ticks_per_overflow),
    .reference_rate     (reference_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_data           (out_data)
  );

endmodule

`default_nettype wire

[hdl/cpfm_checker.sv]
// ----------------------------------------------------------------------------
// cpfm_checker
// port-level checks on the meter results, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cpfm_checker
  import cpfm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.zero_period == (out_data.period_ticks == '0)))
    else $error("zero flag disagrees with period");

  a_zero_freq: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_period |-> out_data.freq_millihertz == '0)
    else $error("nonzero frequency for zero period");

  a_freq_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.freq_millihertz <= FREQ_MAX)
    else $error("frequency above saturation limit");

endmodule

bind capture_period_frequency_meter_top cpfm_checker u_cpfm_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the capture period and frequency meter: a queue of
// overflow ticks and capture edges is driven in bursts with random gaps, a
// local copy of the meter predicts each period and frequency, and a monitor
// compares every result against the oldest prediction under random output
// stalls. register settings change between phases once the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import cpfm_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 60;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_TPO;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  in_item_t  event_q[$];
  out_item_t meas_q[$];
  out_item_t want;

  // meter state mirrored by the predictor
  logic [CNT32_W-1:0] ovf_count   = '0;
  logic [CNT32_W-1:0] first_stamp = '0;
  logic [CAP_W-1:0]   first_cap   = '0;
  logic               armed       = 1'b0;
  logic [TPO_W-1:0]   tpo         = TPO_RESET;
  logic [RATE_W-1:0]  rate        = RATE_RESET;

  int errors      = 0;
  int gap_left    = 0;
  int burst_left  = 0;
  int stall_run   = 0;
  int idle_cycles = 0;
  int stall_mode  = 0;
  bit stall_level = 1'b0;
  bit gaps_on     = 1'b0;
  bit gen_armed   = 1'b0;

  always #4 clk = ~clk;

  capture_period_frequency_meter_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  task automatic measure_event(input in_item_t ev);
    logic [CNT32_W-1:0] period;
    logic [63:0]        quot;
    out_item_t          res;
    if (ev.operation == OP_OVERFLOW) begin
      ovf_count = ovf_count + 1'b1;
    end else if (!armed) begin
      first_cap   = ev.capture_value;
      first_stamp = ovf_count;
      armed       = 1'b1;
    end else begin
      armed  = 1'b0;
      period = (ovf_count - first_stamp) * CNT32_W'(tpo)
               + CNT32_W'(ev.capture_value) - CNT32_W'(first_cap);
      res.period_ticks = period;
      if (period == '0) begin
        res.freq_millihertz = '0;
        res.zero_period     = 1'b1;
      end else begin
        quot = (64'(rate) * 64'(MILLI)) / 64'(period);
        if (quot > 64'(FREQ_MAX)) begin
          quot = 64'(FREQ_MAX);
        end
        res.freq_millihertz = FREQ_W'(quot);
        res.zero_period     = 1'b0;
      end
      meas_q.push_back(res);
    end
  endtask

  task automatic push_event(input logic op, input logic [CAP_W-1:0] val);
    in_item_t ev;
    ev.operation     = op;
    ev.capture_value = val;
    event_q.push_back(ev);
    if (op == OP_CAPTURE) begin
      gen_armed = ~gen_armed;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_TPO) begin
      tpo = val[TPO_W-1:0];
    end else begin
      rate = val;
    end
  endtask

  // checks at the falling edge so the driver's updates have settled
  task automatic drain_and_settle();
    @(posedge clk);
    @(negedge clk);
    while (event_q.size() != 0 || in_valid || meas_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly complete capture pairs with ticks between, some lone items
  task automatic push_random(input int n_items);
    int                 pushed;
    int                 n_ticks;
    logic [CAP_W-1:0]   c0;
    logic [CAP_W-1:0]   c1;
    pushed = 0;
    while (pushed < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        if (gen_armed) begin
          push_event(OP_CAPTURE, CAP_W'($urandom));
          pushed++;
        end
        c0 = CAP_W'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          c1 = c0 + CAP_W'($urandom_range(0, 3));
        end else begin
          c1 = CAP_W'($urandom);
        end
        n_ticks = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
        push_event(OP_CAPTURE, c0);
        repeat (n_ticks) push_event(OP_OVERFLOW, CAP_W'($urandom));
        push_event(OP_CAPTURE, c1);
        pushed += n_ticks + 2;
      end else begin
        push_event($urandom_range(0, 1) ? OP_CAPTURE : OP_OVERFLOW, CAP_W'($urandom));
        pushed++;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        measure_event(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (event_q.size() != 0) begin
          in_data  <= event_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = gaps_on ? $urandom_range(0, 10) : 0;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (meas_q.size() == 0) begin
          $error("result with nothing expected: period_ticks %0d", out_data.period_ticks);
          errors++;
        end else begin
          want = meas_q.pop_front();
          if (out_data.period_ticks !== want.period_ticks) begin
            $error("period_ticks: expected %0d, got %0d",
                   want.period_ticks, out_data.period_ticks);
            errors++;
          end
          if (out_data.freq_millihertz !== want.freq_millihertz) begin
            $error("freq_millihertz: expected %0d, got %0d",
                   want.freq_millihertz, out_data.freq_millihertz);
            errors++;
          end
          if (out_data.zero_period !== want.zero_period) begin
            $error("zero_period: expected %0d, got %0d",
                   want.zero_period, out_data.zero_period);
            errors++;
          end
        end
      end
      case (stall_mode)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (stall_run == 0) begin
            stall_level = ~stall_level;
            stall_run   = stall_level ? $urandom_range(1, 20) : $urandom_range(1, 30);
          end else begin
            stall_run--;
          end
          out_stall <= stall_level;
        end
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // default registers: one overflow, zero period, negative wrap, saturation
    push_event(OP_CAPTURE, 16'h0000);
    push_event(OP_OVERFLOW, 16'hFFFF);
    push_event(OP_CAPTURE, 16'h0000);
    push_event(OP_CAPTURE, 16'hFFFF);
    push_event(OP_CAPTURE, 16'hFFFF);
    push_event(OP_CAPTURE, 16'hFFFF);
    push_event(OP_CAPTURE, 16'h0000);
    push_event(OP_CAPTURE, 16'd100);
    push_event(OP_CAPTURE, 16'd101);
    push_event(OP_CAPTURE, 16'd5);
    repeat (3) push_event(OP_OVERFLOW, 16'h0000);
    push_event(OP_CAPTURE, 16'd3);
    drain_and_settle();

    // zero registers: capture difference only, frequency forced to zero
    write_reg(CFG_TPO, '0);
    write_reg(CFG_RATE, '0);
    push_event(OP_CAPTURE, 16'd10);
    push_event(OP_OVERFLOW, 16'h5555);
    push_event(OP_CAPTURE, 16'd20);
    push_event(OP_CAPTURE, 16'd9);
    push_event(OP_OVERFLOW, 16'hAAAA);
    push_event(OP_CAPTURE, 16'd9);
    drain_and_settle();

    // all-ones write, ticks register masked to its width
    write_reg(CFG_TPO, '1);
    write_reg(CFG_RATE, '1);
    push_event(OP_CAPTURE, 16'hFFFF);
    repeat (2) push_event(OP_OVERFLOW, 16'h0000);
    push_event(OP_CAPTURE, 16'h0000);
    drain_and_settle();

    write_reg(CFG_TPO, CFG_DATA_W'(65536));
    write_reg(CFG_RATE, CFG_DATA_W'(1));
    push_event(OP_CAPTURE, 16'h0000);
    push_event(OP_OVERFLOW, 16'h0000);
    push_event(OP_CAPTURE, 16'h0000);
    drain_and_settle();

    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 4))
        0:       write_reg(CFG_TPO, CFG_DATA_W'(1));
        1:       write_reg(CFG_TPO, CFG_DATA_W'(65536));
        2:       write_reg(CFG_TPO, CFG_DATA_W'($urandom_range(1, 16)));
        default: write_reg(CFG_TPO, CFG_DATA_W'($urandom));
      endcase
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_RATE, CFG_DATA_W'(1));
        1:       write_reg(CFG_RATE, '1);
        default: write_reg(CFG_RATE, CFG_DATA_W'($urandom));
      endcase
      gaps_on    = (ph % 3 != 0);
      stall_mode = ph % 3;
      if (ph == 4) begin
        // sender holds off mid phase until every result is back
        push_random(25);
        drain_and_settle();
        push_random(25);
      end else begin
        push_random(50);
      end
      drain_and_settle();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
